[design/tbrl_pkg.sv]
package tbrl_pkg;

	// request kinds (s_tuser)
	localparam logic [1:0] ACT_RESERVE = 2'd0;
	localparam logic [1:0] ACT_REFUND  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// result status (m_tuser)
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SHORT = 2'd1;
	localparam logic [1:0] STAT_ZERO  = 2'd2;

	localparam logic [31:0] ONE_SEC_NS = 32'd1_000_000_000;
	localparam logic [31:0] RATE_RESET = 32'd1000;

	// floor(2^61 / 1e9): ((x >> 32) * NS_RECIP) >> 29 undershoots x / 1e9 by at most 7
	localparam logic [31:0] NS_RECIP = 32'd2_305_843_009;

	// (elapsed * rate mod 2^64) / 1e9 is below 2^35
	localparam int ADDED_W = 35;

	// restoring divider steps for the full 64-bit quotient
	localparam logic [6:0] DIV_STEPS_FULL = 7'd64;

	typedef struct packed {
		logic start;
	} div_ctl_t;

endpackage

[design/token_bucket_rate_limiter_top.sv]
// Token bucket rate limiter.
// Request words come in on s_tvalid/s_tready/s_tdata/s_tuser; one result word
// per request leaves on m_tvalid/m_tready/m_tdata/m_tuser. The bucket rate
// (also its capacity) is written through cfg_we/cfg_wdata while idle.
// One request is worked at a time; s_tready is high only while idle.
// Paths from accept to result: refund, restart and zero-count reserve go
// from EVAL straight to DONE; a reserve on a full bucket, with no time
// passed or at rate 0 goes through TAKE; a reserve whose refill adds no
// token first runs the multiply and /1e9 fixup states; a reserve with a
// refill also waits for the divider.
// The refill path uses the iterative restoring divider for
// added*1e9/rate, 64 steps at one quotient bit per cycle. elapsed*rate/1e9
// uses a reciprocal estimate on the shared registered 32x32 multiplier and
// up to seven compare-subtract fixups, one per cycle.
// Results go to an output register; a stalled receiver holds the finished
// word there, the next request is still accepted, and its result waits in
// the last sequencer state until the register frees up.
// Reset: rate = 1000, bucket level = 1000, refill stamp = 0, no word pending.
module token_bucket_rate_limiter_top
	import tbrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,   // tokens_per_second
	// request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,     // [63:0] now_time, [95:64] token_count
	input  logic [1:0]  s_tuser,     // [1:0] action
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [31:0] tokens_left
	output logic [1:0]  m_tuser      // [1:0] status
);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EVAL = 4'd1;  // decode request, fast paths
	localparam logic [3:0] ST_MA0  = 4'd2;  // elapsed lo * rate
	localparam logic [3:0] ST_MA1  = 4'd3;  // elapsed hi * rate
	localparam logic [3:0] ST_MA2  = 4'd4;  // sum into acc
	localparam logic [3:0] ST_QE   = 4'd5;  // (acc >> 32) * reciprocal
	localparam logic [3:0] ST_QM0  = 4'd6;  // keep estimate, est lo * 1e9
	localparam logic [3:0] ST_QM1  = 4'd7;  // subtract lo product, est hi * 1e9
	localparam logic [3:0] ST_QS   = 4'd8;  // subtract hi product
	localparam logic [3:0] ST_QFIX = 4'd9;  // fix estimate while remainder >= 1e9
	localparam logic [3:0] ST_MB0  = 4'd10; // added lo * 1e9
	localparam logic [3:0] ST_MB1  = 4'd11; // added hi * 1e9
	localparam logic [3:0] ST_MB2  = 4'd12; // sum, start /rate
	localparam logic [3:0] ST_DB   = 4'd13; // wait for stamp advance
	localparam logic [3:0] ST_TAKE = 4'd14; // take tokens from bucket
	localparam logic [3:0] ST_DONE = 4'd15; // hand word to output register

	logic [3:0]  state_q;
	logic [31:0] rate_q;
	logic [31:0] level_q;
	logic [63:0] stamp_q;

	// request and work registers
	logic [1:0]         action_q;
	logic [63:0]        now_q;
	logic [31:0]        count_q;
	logic [63:0]        elapsed_q;
	logic [ADDED_W-1:0] added_q;
	logic [63:0]        acc_q;
	logic [1:0]         st_q;

	// output register
	logic        m_tvalid_q;
	logic [31:0] m_left_q;
	logic [1:0]  m_status_q;

	// shared units
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	div_ctl_t    div_ctl;
	logic [63:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_busy;
	logic        div_done;
	logic [63:0] div_q;

	logic [32:0] refund_sum;
	logic [35:0] refill_sum;
	logic [63:0] used;
	logic        fix_ge;

	tbrl_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	tbrl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// 64x32 low product as two 32x32 passes: lo + (hi << 32)
	always_comb begin
		unique case (state_q)
			ST_MA1:  mul_a = elapsed_q[63:32];
			ST_QE:   mul_a = acc_q[63:32];
			ST_QM0:  mul_a = mul_p[60:29];   // low word of the estimate
			ST_MB0:  mul_a = added_q[31:0];
			ST_QM1,
			ST_MB1:  mul_a = {29'd0, added_q[ADDED_W-1:32]};
			default: mul_a = elapsed_q[31:0];
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_QE:   mul_b = NS_RECIP;
			ST_QM0,
			ST_QM1,
			ST_MB0,
			ST_MB1:  mul_b = ONE_SEC_NS;
			default: mul_b = rate_q;
		endcase
	end

	assign div_dividend  = acc_q + {mul_p[31:0], 32'd0};
	assign div_divisor   = rate_q;
	assign div_ctl.start = (state_q == ST_MB2);

	// remainder of the /1e9 estimate still holds a whole second
	assign fix_ge = (acc_q >= {32'd0, ONE_SEC_NS});

	assign refund_sum = {1'b0, level_q} + {1'b0, count_q};
	assign refill_sum = {4'd0, level_q} + {1'b0, added_q};
	// stamp never moves past now
	assign used       = (div_q > elapsed_q) ? elapsed_q : div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rate_q     <= RATE_RESET;
			level_q    <= RATE_RESET;
			stamp_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					unique case (action_q)
						ACT_RESERVE: begin
							priority if (count_q == 32'd0) begin
								state_q <= ST_DONE;
							end else if (rate_q == 32'd0) begin
								state_q <= ST_TAKE;
							end else if (level_q >= rate_q) begin
								// lazy clamp after a lowered rate
								level_q <= rate_q;
								stamp_q <= now_q;
								state_q <= ST_TAKE;
							end else if (now_q == stamp_q) begin
								state_q <= ST_TAKE;
							end else begin
								state_q <= ST_MA0;
							end
						end
						ACT_REFUND: begin
							if (count_q != 32'd0) begin
								level_q <= (refund_sum > {1'b0, rate_q}) ?
									rate_q : refund_sum[31:0];
							end
							state_q <= ST_DONE;
						end
						ACT_RESTART: begin
							level_q <= rate_q;
							stamp_q <= now_q;
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_MA0:  state_q <= ST_MA1;
				ST_MA1:  state_q <= ST_MA2;
				ST_MA2:  state_q <= ST_QE;
				ST_QE:   state_q <= ST_QM0;
				ST_QM0:  state_q <= ST_QM1;
				ST_QM1:  state_q <= ST_QS;
				ST_QS:   state_q <= ST_QFIX;
				ST_QFIX: begin
					if (!fix_ge) begin
						if (added_q == '0) begin
							state_q <= ST_TAKE;
						end else begin
							level_q <= (refill_sum > {4'd0, rate_q}) ?
								rate_q : refill_sum[31:0];
							state_q <= ST_MB0;
						end
					end
				end
				ST_MB0:  state_q <= ST_MB1;
				ST_MB1:  state_q <= ST_MB2;
				ST_MB2:  state_q <= ST_DB;
				ST_DB: begin
					if (div_done) begin
						stamp_q <= stamp_q + used;
						state_q <= ST_TAKE;
					end
				end
				ST_TAKE: begin
					if (level_q >= count_q) begin
						level_q <= level_q - count_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			action_q <= s_tuser;
			now_q    <= s_tdata[63:0];
			count_q  <= s_tdata[95:64];
		end
		if (state_q == ST_EVAL) begin
			elapsed_q <= now_q - stamp_q;
			st_q      <= (action_q == ACT_RESERVE && count_q == 32'd0) ? STAT_ZERO : STAT_OK;
		end
		// acc: product sum, then remainder of the /1e9 estimate
		if (state_q == ST_MA1 || state_q == ST_MB1) begin
			acc_q <= mul_p;
		end
		if (state_q == ST_MA2) begin
			acc_q <= acc_q + {mul_p[31:0], 32'd0};
		end
		if (state_q == ST_QM1) begin
			acc_q <= acc_q - mul_p;
		end
		if (state_q == ST_QS) begin
			acc_q <= acc_q - {mul_p[31:0], 32'd0};
		end
		if (state_q == ST_QM0) begin
			added_q <= mul_p[63:29];
		end
		if (state_q == ST_QFIX && fix_ge) begin
			acc_q   <= acc_q - {32'd0, ONE_SEC_NS};
			added_q <= added_q + ADDED_W'(1);
		end
		if (state_q == ST_TAKE && level_q < count_q) begin
			st_q <= STAT_SHORT;
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_status_q <= st_q;
			m_left_q   <= level_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_left_q;
	assign m_tuser  = m_status_q;

	// a request is worked alone: no second accept right after one
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");

	// a finished word waits while the output register is still full
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid_q && !m_tready) |=> (state_q == ST_DONE))
		else $error("result dropped on stalled output");

	// divider only finishes while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DB))
		else $error("divider done outside wait state");

	// divider is idle whenever a new request can come in
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("divider busy while idle");

endmodule

[design/tbrl_mul.sv]
module tbrl_mul
	import tbrl_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

[design/tbrl_div.sv]
module tbrl_div
	import tbrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] sh_q;
	logic [31:0] dvs_q;

	logic [32:0] r2;
	logic [33:0] diff;
	logic        ge;

	// one restoring step per cycle
	assign r2   = {rem_q, sh_q[63]};
	assign diff = {1'b0, r2} - {2'b00, dvs_q};
	assign ge   = ~diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS_FULL;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			sh_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : r2[31:0];
			sh_q  <= {sh_q[62:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = sh_q;

endmodule

[tb/tb_token_bucket_rate_limiter_top.sv]
module tb_token_bucket_rate_limiter_top
	import tbrl_pkg::*;
();

	// run ceiling in clocks
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_PCT = 7;
	localparam int MAX_PRINTS = 50;
	localparam logic [63:0] NS_PER_S = {32'd0, ONE_SEC_NS};

	// one request word as the block sees it
	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] now_ns;
		logic [31:0] count;
	} bucket_req_t;

	// one result word: status plus level after the request
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] tokens_left;
	} bucket_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	token_bucket_rate_limiter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [63:0] now_time, [95:64] token_count
		.s_tuser   (s_tuser),    // [1:0] action
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [31:0] tokens_left
		.m_tuser   (m_tuser)     // [1:0] status
	);

	always #2 clk = ~clk;

	// shadow copy of the bucket, advanced once per accepted request word
	logic [31:0] bucket_rate  = RATE_RESET;
	logic [31:0] bucket_level = RATE_RESET;
	logic [63:0] bucket_stamp = '0;

	bucket_req_t   request_q[$];   // words waiting for the driver
	bucket_reply_t reply_q[$];     // predicted result words, oldest first
	bucket_req_t   in_flight;      // word currently on the slave side

	logic [63:0] now_ns = '0;      // stimulus time base
	bit          steady = 1'b0;    // no idling on either side while set
	int          err_count = 0;
	int          sent_count = 0;
	int          result_count = 0;
	int          rate_count = 0;
	int          ok_count = 0;
	int          short_count = 0;
	int          zero_count = 0;
	int          cycle_cnt = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (err_count < MAX_PRINTS)
			$display("MISMATCH @%0d: %s got %0h want %0h", cycle_cnt, what, got, want);
		err_count++;
	endtask

	// lazy refill: clamp a full bucket, else add whole tokens for the elapsed
	// time and move the stamp by the time those tokens cost; 64-bit wrap as in C
	function automatic void refill_bucket(input logic [63:0] t_ns);
		logic [63:0] rate64, elapsed, added, total, used;
		rate64 = {32'd0, bucket_rate};
		if (rate64 != 0) begin
			if ({32'd0, bucket_level} >= rate64) begin
				bucket_level = bucket_rate;
				bucket_stamp = t_ns;
			end else begin
				elapsed = t_ns - bucket_stamp;
				added = (elapsed * rate64) / NS_PER_S;
				if (elapsed != 0 && added != 0) begin
					total = {32'd0, bucket_level} + added;
					if (total > rate64)
						total = rate64;
					bucket_level = total[31:0];
					used = (added * NS_PER_S) / rate64;
					if (used > elapsed)
						used = elapsed;
					bucket_stamp = bucket_stamp + used;
				end
			end
		end
	endfunction

	function automatic bucket_reply_t bucket_reply(input bucket_req_t rq);
		bucket_reply_t rp;
		logic [63:0] total;
		rp.status = STAT_OK;
		case (rq.action)
			ACT_RESERVE: begin
				if (rq.count == 0) begin
					rp.status = STAT_ZERO;
				end else begin
					refill_bucket(rq.now_ns);
					if (bucket_level < rq.count)
						rp.status = STAT_SHORT;
					else
						bucket_level = bucket_level - rq.count;
				end
			end
			ACT_REFUND: begin
				if (rq.count != 0) begin
					total = {32'd0, bucket_level} + {32'd0, rq.count};
					if (total > {32'd0, bucket_rate})
						total = {32'd0, bucket_rate};
					bucket_level = total[31:0];
				end
			end
			ACT_RESTART: begin
				bucket_level = bucket_rate;
				bucket_stamp = rq.now_ns;
			end
			default: ;
		endcase
		rp.tokens_left = bucket_level;
		return rp;
	endfunction

	// driver: retire the accepted word into the prediction, then offer the next
	always @(posedge clk) begin : drive_blk
		bit fire;
		if (arst_n) begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				reply_q.push_back(bucket_reply(in_flight));
				sent_count++;
			end
			if (!s_tvalid || fire) begin
				if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_flight = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {in_flight.count, in_flight.now_ns};
					s_tuser  <= in_flight.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result word with the oldest prediction, stall at random
	always @(posedge clk) begin : watch_blk
		bucket_reply_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					report_mismatch("result word with no request pending", m_tdata, 0);
				end else begin
					want = reply_q.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
					if (m_tdata !== want.tokens_left)
						report_mismatch("tokens_left", m_tdata, want.tokens_left);
					case (want.status)
						STAT_OK:    ok_count++;
						STAT_SHORT: short_count++;
						default:    zero_count++;
					endcase
				end
				result_count++;
			end
			m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				reply_q.size());
			$display("token_bucket_rate_limiter_top verification failed");
			$finish;
		end
	end

	task automatic push_req(input logic [1:0] act, input logic [63:0] t_ns,
			input logic [31:0] cnt);
		bucket_req_t rq;
		rq.action = act;
		rq.now_ns = t_ns;
		rq.count  = cnt;
		request_q.push_back(rq);
	endtask

	// sampled at the falling edge so every edge-time update has settled
	task automatic wait_drained();
		@(negedge clk);
		while (request_q.size() != 0 || s_tvalid || reply_q.size() != 0)
			@(negedge clk);
	endtask

	// rate register only changes with nothing in flight
	task automatic set_rate(input logic [31:0] r);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		bucket_rate = r;
		rate_count++;
		@(negedge clk);
	endtask

	// mostly ordered time steps sized to the token period, with some jumps,
	// wraps and time going backward; counts sized to the bucket mostly
	task automatic queue_random(input int n);
		logic [63:0] period;
		logic [31:0] cnt_cap, cnt;
		logic [1:0]  act;
		int r;
		period = NS_PER_S / {32'd0, bucket_rate};
		if (period == 0)
			period = 1;
		cnt_cap = (bucket_rate < 16) ? bucket_rate + 1 : bucket_rate / 4;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				;
			else if (r < 70)
				now_ns += $urandom_range(0, 3 * period[31:0]);
			else if (r < 85)
				now_ns += $urandom();
			else if (r < 93)
				now_ns += {$urandom(), $urandom()} >> $urandom_range(0, 63);
			else
				now_ns = {$urandom(), $urandom()};
			r = $urandom_range(0, 99);
			act = (r < 62) ? ACT_RESERVE : (r < 88) ? ACT_REFUND : ACT_RESTART;
			r = $urandom_range(0, 99);
			if (r < 72)
				cnt = $urandom_range(1, cnt_cap);
			else if (r < 80)
				cnt = '0;
			else if (r < 90)
				cnt = $urandom();
			else
				cnt = bucket_rate + $urandom_range(0, 1);
			push_req(act, now_ns, cnt);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pass at the reset rate: level 1000, stamp 0
		set_rate(32'd1000);
		push_req(ACT_RESERVE, 64'd0, 32'd0);               // zero count refused
		push_req(ACT_RESERVE, 64'd0, 32'd1);               // full bucket clamp
		push_req(ACT_RESERVE, 64'd0, 32'd1000);            // short, no time passed
		push_req(ACT_REFUND,  64'd0, 32'd0);               // empty refund
		push_req(ACT_REFUND,  64'd0, 32'd1);
		push_req(ACT_RESERVE, 64'd0, 32'd999);
		push_req(ACT_REFUND,  64'd0, 32'hFFFF_FFFF);       // refund capped at rate
		push_req(ACT_RESERVE, 64'd0, 32'd1000);            // drain to zero
		push_req(ACT_RESERVE, 64'd1_000_000, 32'd5);       // one token back, still short
		push_req(ACT_RESERVE, 64'd1_999_999, 32'd1);       // under one token of time
		push_req(ACT_RESERVE, 64'd2_000_000, 32'd1);
		push_req(ACT_RESERVE, 64'd2_500_000, 32'd1);
		push_req(ACT_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF); // product wraps
		push_req(ACT_RESTART, 64'd5_000_000_000, 32'hFFFF_FFFF);
		push_req(ACT_RESERVE, 64'd5_000_000_000, 32'hFFFF_FFFF);
		push_req(ACT_RESERVE, 64'd5_000_000_000, 32'd600);
		push_req(ACT_RESERVE, 64'd4_000_000_000, 32'd500); // time went backward
		push_req(ACT_REFUND,  64'd0, 32'h8000_0000);
		push_req(ACT_RESERVE, 64'd0, 32'd1);
		push_req(ACT_RESTART, 64'd0, 32'd0);
		push_req(ACT_RESERVE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		push_req(ACT_RESERVE, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		wait_drained();

		now_ns = 64'd7_000_000_000;
		set_rate(32'd1);                    // slowest rate, smallest bucket
		queue_random(80);
		wait_drained();

		set_rate(32'hFFFF_FFFF);            // largest rate: wraps within seconds
		queue_random(80);
		wait_drained();

		set_rate(32'd1_000_000);
		steady = 1'b1;                      // back-to-back stretch, no idling
		queue_random(100);
		wait_drained();
		steady = 1'b0;

		set_rate($urandom_range(2, 5000));
		queue_random(100);
		wait_drained();

		set_rate($urandom() | 32'd1);
		queue_random(100);
		wait_drained();

		set_rate(ONE_SEC_NS);               // one token per nanosecond
		queue_random(100);
		wait_drained();

		set_rate(32'd3);                    // lowered rate: held level gets clamped
		queue_random(90);
		wait_drained();

		repeat (150) @(posedge clk);
		if (reply_q.size() != 0)
			report_mismatch("results never delivered", reply_q.size(), 0);

		$display("%0d requests over %0d rate settings, %0d results checked",
			sent_count, rate_count, result_count);
		$display("status mix: %0d done, %0d short, %0d zero count; %0d mismatches",
			ok_count, short_count, zero_count, err_count);
		if (err_count == 0)
			$display("token_bucket_rate_limiter_top verification clean");
		else
			$display("token_bucket_rate_limiter_top verification failed");
		$finish;
	end

endmodule
